// ===== rtl/remote_byte_to_motor_drive_top_macros.svh =====
// Assertion macros for the remote byte to motor drive checker.
// Included by the checker module only; relies on clock, reset, rsp_valid and rsp_ready in scope.
`ifndef REMOTE_BYTE_TO_MOTOR_DRIVE_TOP_MACROS_SVH
`define REMOTE_BYTE_TO_MOTOR_DRIVE_TOP_MACROS_SVH

// Check a condition on every response shown on the port.
`define RBMD_ASSERT_ON_RSP(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      rsp_valid |-> (cond)) else $error(msg);

// Check that a stalled response stays up with the same payload.
`define RBMD_ASSERT_HOLD(label, payload, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(payload)) else $error(msg);

`endif

// ===== rtl/rbmd_pkg.sv =====
// Shared constants and types for the remote byte to motor drive block.
// No dependencies; used by rbmd_decode, rbmd_drive and the top level.
package rbmd_pkg;

   localparam int STICK_CHANNELS = 4;
   localparam int STICK_OUTPUTS  = 4;
   localparam int CSR_INDEX_W    = 2;

   localparam logic [7:0]  HDR_LO      = 8'd201;
   localparam logic [7:0]  HDR_HI      = 8'd254;
   localparam logic [7:0]  BTN_LO      = 8'd231;
   localparam logic [7:0]  BTN_HI      = 8'd246;
   localparam logic [7:0]  DATA_HI     = 8'd200;
   localparam logic [15:0] SPEED_RESET = 16'd150;
   localparam logic [7:0]  STEP_RESET  = 8'd10;
   localparam logic [7:0]  DBAND_RESET = 8'd5;
   localparam logic [7:0]  LIMIT_RESET = 8'd255;

   // Button codes (byte minus BTN_LO)
   localparam logic [3:0] BTN_ENABLE_LAST = 4'd8;
   localparam logic [3:0] BTN_UP          = 4'd10;
   localparam logic [3:0] BTN_LEFT        = 4'd11;
   localparam logic [3:0] BTN_DOWN        = 4'd12;
   localparam logic [3:0] BTN_RIGHT       = 4'd13;
   localparam logic [3:0] BTN_START       = 4'd14;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPEED_STEP  = 2'd0,
      CSR_DEAD_BAND   = 2'd1,
      CSR_DRIVE_LIMIT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                               drive_enabled;
      logic                               start_toggle;
      logic signed [15:0]                 speed_a;
      logic signed [15:0]                 speed_b;
      logic [STICK_CHANNELS-1:0][7:0]     stick;
   } state_type;

   typedef struct packed {
      logic       fwd;
      logic       rev;
      logic [7:0] pwm;
   } drive_type;

   typedef struct packed {
      drive_type                       motor_a;
      drive_type                       motor_b;
      logic                            drive_on;
      logic                            start_flag;
      logic [STICK_OUTPUTS-1:0][7:0]   stick;
   } rsp_type;

endpackage

// ===== rtl/rbmd_if.sv =====
// Request and response channel interfaces (valid/ready plus payload).
// Depends on nothing; used by the top level.
interface rbmd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rbmd_rsp_if;
   logic       valid;
   logic       ready;
   logic       motor_a_fwd;
   logic       motor_a_rev;
   logic [7:0] motor_a_pwm;
   logic       motor_b_fwd;
   logic       motor_b_rev;
   logic [7:0] motor_b_pwm;
   logic       drive_on;
   logic       start_flag;
   logic [7:0] stick_0;
   logic [7:0] stick_1;
   logic [7:0] stick_2;
   logic [7:0] stick_3;

   modport source (output valid, input ready,
                   output motor_a_fwd, output motor_a_rev, output motor_a_pwm,
                   output motor_b_fwd, output motor_b_rev, output motor_b_pwm,
                   output drive_on, output start_flag,
                   output stick_0, output stick_1, output stick_2, output stick_3);
   modport sink   (input valid, output ready,
                   input motor_a_fwd, input motor_a_rev, input motor_a_pwm,
                   input motor_b_fwd, input motor_b_rev, input motor_b_pwm,
                   input drive_on, input start_flag,
                   input stick_0, input stick_1, input stick_2, input stick_3);
endinterface

// ===== rtl/rbmd_decode.sv =====
// Byte decoder and control state: header, buttons, speeds, stick channels.
// Depends on rbmd_pkg.
module rbmd_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [7:0]           rx_byte,
   input  logic [7:0]           speed_step,
   output rbmd_pkg::state_type  state
);

   rbmd_pkg::state_type state_ff, state_in;
   logic [7:0]          last_header_ff, last_header_in;
   logic                is_hdr, is_btn, is_data, hdr_valid;
   logic [3:0]          button;
   logic [7:0]          chan;

   function automatic logic signed [15:0] sat_step(input logic signed [15:0] v,
                                                   input logic [7:0] step,
                                                   input logic down);
      logic signed [16:0] sum;
      sum = down ? ({v[15], v} - {9'd0, step}) : ({v[15], v} + {9'd0, step});
      if (sum[16] != sum[15]) begin
         sat_step = sum[16] ? 16'sh8000 : 16'sh7fff;
      end else begin
         sat_step = sum[15:0];
      end
   endfunction

   always_comb begin
      is_hdr    = (rx_byte >= rbmd_pkg::HDR_LO) && (rx_byte <= rbmd_pkg::HDR_HI);
      is_btn    = (rx_byte >= rbmd_pkg::BTN_LO) && (rx_byte <= rbmd_pkg::BTN_HI);
      is_data   = (rx_byte <= rbmd_pkg::DATA_HI);
      button    = 4'(rx_byte - rbmd_pkg::BTN_LO);
      hdr_valid = (last_header_ff >= rbmd_pkg::HDR_LO);
      chan      = last_header_ff - rbmd_pkg::HDR_LO;

      state_in       = state_ff;
      last_header_in = last_header_ff;
      if (is_hdr) begin
         last_header_in = rx_byte;
      end
      if (is_btn) begin
         if (button <= rbmd_pkg::BTN_ENABLE_LAST) begin
            state_in.drive_enabled = !state_ff.drive_enabled;
         end else if (button == rbmd_pkg::BTN_UP) begin
            state_in.speed_a = sat_step(state_ff.speed_a, speed_step, 1'b0);
         end else if (button == rbmd_pkg::BTN_LEFT) begin
            state_in.speed_b = sat_step(state_ff.speed_b, speed_step, 1'b0);
         end else if (button == rbmd_pkg::BTN_DOWN) begin
            state_in.speed_a = sat_step(state_ff.speed_a, speed_step, 1'b1);
         end else if (button == rbmd_pkg::BTN_RIGHT) begin
            state_in.speed_b = sat_step(state_ff.speed_b, speed_step, 1'b1);
         end else if (button == rbmd_pkg::BTN_START) begin
            state_in.start_toggle = !state_ff.start_toggle;
         end
      end
      // drop data when no channel header is in force
      for (int k = 0; k < rbmd_pkg::STICK_CHANNELS; k++) begin
         if (is_data && hdr_valid && (chan == 8'(k))) begin
            state_in.stick[k] = rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.drive_enabled <= 1'b0;
         state_ff.start_toggle  <= 1'b0;
         state_ff.speed_a       <= rbmd_pkg::SPEED_RESET;
         state_ff.speed_b       <= rbmd_pkg::SPEED_RESET;
         state_ff.stick         <= '0;
         last_header_ff         <= 8'd0;
      end else if (load) begin
         state_ff       <= state_in;
         last_header_ff <= last_header_in;
      end
   end

   assign state = state_ff;

endmodule

// ===== rtl/rbmd_drive.sv =====
// Motor drive mapping: enable gate, symmetric clamp, dead band, sign to direction lines.
// Depends on rbmd_pkg.
module rbmd_drive (
   input  logic                 enable,
   input  logic signed [15:0]   speed,
   input  logic [7:0]           drive_limit,
   input  logic [7:0]           dead_band,
   output rbmd_pkg::drive_type  drive
);

   logic        neg;
   logic [16:0] mag;
   logic [7:0]  mag_clamped;

   always_comb begin
      neg = enable && speed[15];
      if (!enable) begin
         mag = 17'd0;
      end else if (speed[15]) begin
         mag = 17'd0 - {speed[15], speed};
      end else begin
         mag = {1'b0, speed};
      end
      mag_clamped = (mag > {9'd0, drive_limit}) ? drive_limit : mag[7:0];

      if (mag_clamped > dead_band) begin
         drive.fwd = !neg;
         drive.rev = neg;
         drive.pwm = mag_clamped;
      end else begin
         drive.fwd = 1'b0;
         drive.rev = 1'b0;
         drive.pwm = 8'd0;
      end
   end

endmodule

// ===== rtl/remote_byte_to_motor_drive_top.sv =====
// Top level of the remote byte to motor drive block: CSRs, pipeline and result register.
// Depends on rbmd_pkg, rbmd_if, rbmd_decode and rbmd_drive.
//
//   channel   dir   handshake        payload
//   req_ch    in    valid/ready      rx_byte
//   rsp_ch    out   valid/ready      motor A/B fwd, rev, pwm; drive_on; start_flag; stick_0..3
//   csr_*     in    csr_we           csr_index, csr_wdata
//
// One request per cycle while the response is not stalled; each taken request passes through the
// input register, state update and result register. Drive outputs come from the state
// registers, so the saturating speed add and the clamp sit in separate stages.
// Reset is synchronous; it clears the valid bits, state and CSRs to their defaults.
// A stalled response backs up the pipeline; req_ch.ready drops only once all stages are full.
module remote_byte_to_motor_drive_top (
   input  logic                               clock,
   input  logic                               reset,
   rbmd_req_if.sink                           req_ch,
   rbmd_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [rbmd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [7:0]                         csr_wdata
);

   logic [7:0] speed_step_ff, dead_band_ff, drive_limit_ff;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       mid_valid_ff;
   logic       rsp_valid_ff;

   rbmd_pkg::rsp_type   rsp_ff, rsp_in;
   rbmd_pkg::state_type state;
   rbmd_pkg::drive_type drive_a, drive_b;

   logic in_advance, mid_advance;
   logic [rbmd_pkg::STICK_OUTPUTS-1:0][7:0] stick_view;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_step_ff  <= rbmd_pkg::STEP_RESET;
         dead_band_ff   <= rbmd_pkg::DBAND_RESET;
         drive_limit_ff <= rbmd_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         case (rbmd_pkg::csr_index_type'(csr_index))
            rbmd_pkg::CSR_SPEED_STEP:  speed_step_ff  <= csr_wdata;
            rbmd_pkg::CSR_DEAD_BAND:   dead_band_ff   <= csr_wdata;
            rbmd_pkg::CSR_DRIVE_LIMIT: drive_limit_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // advance each stage when the next one is empty or moving
   assign mid_advance  = mid_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign in_advance   = in_valid_ff && (!mid_valid_ff || mid_advance);
   assign req_ch.ready = !in_valid_ff || in_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (!mid_valid_ff || mid_advance) begin
            mid_valid_ff <= in_valid_ff;
         end
         if (!rsp_valid_ff || rsp_ch.ready) begin
            rsp_valid_ff <= mid_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.rx_byte;
      end
      if (mid_advance) begin
         rsp_ff <= rsp_in;
      end
   end

   rbmd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .load       (in_advance),
      .rx_byte    (in_byte_ff),
      .speed_step (speed_step_ff),
      .state      (state)
   );

   rbmd_drive u_drive_a (
      .enable      (state.drive_enabled),
      .speed       (state.speed_a),
      .drive_limit (drive_limit_ff),
      .dead_band   (dead_band_ff),
      .drive       (drive_a)
   );

   rbmd_drive u_drive_b (
      .enable      (state.drive_enabled),
      .speed       (state.speed_b),
      .drive_limit (drive_limit_ff),
      .dead_band   (dead_band_ff),
      .drive       (drive_b)
   );

   // unused stick outputs read zero
   for (genvar j = 0; j < rbmd_pkg::STICK_OUTPUTS; j++) begin : g_stick
      if (j < rbmd_pkg::STICK_CHANNELS) begin : g_used
         assign stick_view[j] = state.stick[j];
      end else begin : g_unused
         assign stick_view[j] = 8'd0;
      end
   end

   always_comb begin
      rsp_in.motor_a    = drive_a;
      rsp_in.motor_b    = drive_b;
      rsp_in.drive_on   = state.drive_enabled;
      rsp_in.start_flag = state.start_toggle;
      rsp_in.stick      = stick_view;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.motor_a_fwd = rsp_ff.motor_a.fwd;
   assign rsp_ch.motor_a_rev = rsp_ff.motor_a.rev;
   assign rsp_ch.motor_a_pwm = rsp_ff.motor_a.pwm;
   assign rsp_ch.motor_b_fwd = rsp_ff.motor_b.fwd;
   assign rsp_ch.motor_b_rev = rsp_ff.motor_b.rev;
   assign rsp_ch.motor_b_pwm = rsp_ff.motor_b.pwm;
   assign rsp_ch.drive_on    = rsp_ff.drive_on;
   assign rsp_ch.start_flag  = rsp_ff.start_flag;
   assign rsp_ch.stick_0     = rsp_ff.stick[0];
   assign rsp_ch.stick_1     = rsp_ff.stick[1];
   assign rsp_ch.stick_2     = rsp_ff.stick[2];
   assign rsp_ch.stick_3     = rsp_ff.stick[3];

endmodule

// ===== rtl/rbmd_checker.sv =====
// Port-level checker for the remote byte to motor drive top, bound to every instance.
// Depends on remote_byte_to_motor_drive_top_macros.svh.
`include "remote_byte_to_motor_drive_top_macros.svh"

module rbmd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       a_fwd,
   input logic       a_rev,
   input logic [7:0] a_pwm,
   input logic       b_fwd,
   input logic       b_rev,
   input logic [7:0] b_pwm,
   input logic       drive_on
);

   `RBMD_ASSERT_HOLD(a_rsp_hold, {a_fwd, a_rev, a_pwm, b_fwd, b_rev, b_pwm, drive_on}, "response changed while stalled")
   `RBMD_ASSERT_ON_RSP(a_dir_excl, !(a_fwd && a_rev) && !(b_fwd && b_rev), "both direction lines high")
   `RBMD_ASSERT_ON_RSP(a_pwm_match, ((a_fwd || a_rev) == (a_pwm != 8'd0)) && ((b_fwd || b_rev) == (b_pwm != 8'd0)), "pwm and direction disagree")
   `RBMD_ASSERT_ON_RSP(a_off_idle, drive_on || (a_pwm == 8'd0 && b_pwm == 8'd0), "drive active while disabled")

endmodule

bind remote_byte_to_motor_drive_top rbmd_checker u_rbmd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .a_fwd     (rsp_ch.motor_a_fwd),
   .a_rev     (rsp_ch.motor_a_rev),
   .a_pwm     (rsp_ch.motor_a_pwm),
   .b_fwd     (rsp_ch.motor_b_fwd),
   .b_rev     (rsp_ch.motor_b_rev),
   .b_pwm     (rsp_ch.motor_b_pwm),
   .drive_on  (rsp_ch.drive_on)
);
